FILE: src/uht_pkg.sv
// ---------------------------------------------------------------------------
// Handle table package
// Shared sizes, codes and types of the direct-mapped handle table.
// ---------------------------------------------------------------------------
package uht_pkg;

  localparam int TABLE_SLOTS = 1024;
  localparam int SLOT_BITS   = $clog2(TABLE_SLOTS);
  localparam int COUNT_BITS  = SLOT_BITS + 1;
  localparam int HALF_SLOTS  = TABLE_SLOTS / 2;
  localparam int HANDLE_BITS = 32;
  localparam int REF_BITS    = 32;
  localparam int SHORT_BITS  = 16;
  localparam int CMD_BITS    = 2;
  localparam int STATUS_BITS = 3;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_FREE   = 2'd2,
    CMD_SHORT  = 2'd3
  } uht_cmd_t;

  typedef enum logic [STATUS_BITS-1:0] {
    STATUS_OK        = 3'd0,
    STATUS_INVALID   = 3'd1,
    STATUS_NOT_FOUND = 3'd2,
    STATUS_FULL      = 3'd3,
    STATUS_ZERO_REF  = 3'd4
  } uht_status_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK
  } uht_state_t;

  typedef struct packed {
    logic [HANDLE_BITS-1:0] handle;
    logic [REF_BITS-1:0]    ref_val;
  } uht_entry_t;

  typedef struct packed {
    logic                   a_gt_b;
    logic                   a_eq_b;
    logic [HANDLE_BITS-1:0] b_next;
  } uht_alu_out_t;

  typedef struct packed {
    uht_status_t            status;
    logic [HANDLE_BITS-1:0] handle;
    logic [REF_BITS-1:0]    ref_val;
  } uht_result_t;

endpackage

FILE: src/unique_handle_table_core.sv
// ---------------------------------------------------------------------------
// Unique handle table core
// Direct-mapped table of never-reused handles with allocate, lookup, free
// and short-to-full commands, one result word per command word.
// ---------------------------------------------------------------------------
//   Channel  Handshake            Payload
//   in_      in_valid, in_ready   in_command, in_handle_in, in_store_ref,
//                                 in_short_handle
//   out_     out_valid, out_ready out_status, out_handle, out_ref
//
// Lookup, free, short-to-full and rejected commands pass through the idle and
// check states, and the result word enters the output register from the check
// state once the register is free; an allocate probes slots one per cycle
// through the slot memory until it finds an empty one.
// After reset the store is cleared with in_ready low.
// A waiting output word does not block acceptance of the next command word;
// the sequencer stalls only when its own result cannot enter the register.
// ---------------------------------------------------------------------------
module unique_handle_table_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [uht_pkg::CMD_BITS-1:0]    in_command,
  input  logic [uht_pkg::HANDLE_BITS-1:0] in_handle_in,
  input  logic [uht_pkg::REF_BITS-1:0]    in_store_ref,
  input  logic [uht_pkg::SHORT_BITS-1:0]  in_short_handle,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [uht_pkg::STATUS_BITS-1:0] out_status,
  output logic [uht_pkg::HANDLE_BITS-1:0] out_handle,
  output logic [uht_pkg::REF_BITS-1:0]    out_ref
);

  logic                 out_valid_r, out_valid_nxt;
  uht_pkg::uht_result_t out_word_r, out_word_nxt;
  logic                 out_free;
  logic                 res_valid;
  uht_pkg::uht_result_t res;

  uht_seq u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_handle_in    (in_handle_in),
    .in_store_ref    (in_store_ref),
    .in_short_handle (in_short_handle),
    .out_free        (out_free),
    .res_valid       (res_valid),
    .res             (res)
  );

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid && out_free) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_word_r.status;
  assign out_handle = out_word_r.handle;
  assign out_ref    = out_word_r.ref_val;

endmodule

FILE: src/uht_slot_mem.sv
// ---------------------------------------------------------------------------
// Handle table slot memory
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module uht_slot_mem (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [uht_pkg::SLOT_BITS-1:0] wr_addr,
  input  uht_pkg::uht_entry_t        wr_data,
  input  logic                       rd_en,
  input  logic [uht_pkg::SLOT_BITS-1:0] rd_addr,
  output uht_pkg::uht_entry_t        rd_data
);

  uht_pkg::uht_entry_t mem [uht_pkg::TABLE_SLOTS];
  uht_pkg::uht_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/uht_alu.sv
// ---------------------------------------------------------------------------
// Handle table compare and step unit
// Compares two handles and steps the second to the next nonzero handle.
// ---------------------------------------------------------------------------
module uht_alu (
  input  logic [uht_pkg::HANDLE_BITS-1:0] op_a,
  input  logic [uht_pkg::HANDLE_BITS-1:0] op_b,
  output uht_pkg::uht_alu_out_t           res
);

  logic [uht_pkg::HANDLE_BITS-1:0] inc;

  always_comb begin
    inc        = op_b + uht_pkg::HANDLE_BITS'(1);
    res.a_gt_b = (op_a > op_b);
    res.a_eq_b = (op_a == op_b);
    res.b_next = (inc == '0) ? uht_pkg::HANDLE_BITS'(1) : inc;
  end

endmodule

FILE: src/uht_seq.sv
// ---------------------------------------------------------------------------
// Handle table sequencer
// Clears the store after reset, then runs each command through the memory
// and the shared compare and step unit, one probe per cycle.
// ---------------------------------------------------------------------------
module uht_seq (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [uht_pkg::CMD_BITS-1:0]     in_command,
  input  logic [uht_pkg::HANDLE_BITS-1:0]  in_handle_in,
  input  logic [uht_pkg::REF_BITS-1:0]     in_store_ref,
  input  logic [uht_pkg::SHORT_BITS-1:0]   in_short_handle,
  input  logic                             out_free,
  output logic                             res_valid,
  output uht_pkg::uht_result_t             res
);

  uht_pkg::uht_state_t             state_r, state_nxt;
  logic [uht_pkg::SLOT_BITS-1:0]   clr_addr_r, clr_addr_nxt;
  logic [uht_pkg::HANDLE_BITS-1:0] last_issued_r, last_issued_nxt;
  logic [uht_pkg::COUNT_BITS-1:0]  used_count_r, used_count_nxt;
  uht_pkg::uht_cmd_t               cmd_r, cmd_nxt;
  logic [uht_pkg::HANDLE_BITS-1:0] handle_r, handle_nxt;
  logic [uht_pkg::REF_BITS-1:0]    ref_r, ref_nxt;
  logic                            quick_r, quick_nxt;
  uht_pkg::uht_status_t            quick_status_r, quick_status_nxt;

  logic                            wr_en;
  logic [uht_pkg::SLOT_BITS-1:0]   wr_addr;
  uht_pkg::uht_entry_t             wr_data;
  logic                            rd_en;
  logic [uht_pkg::SLOT_BITS-1:0]   rd_addr;
  uht_pkg::uht_entry_t             rd_data;
  logic [uht_pkg::HANDLE_BITS-1:0] alu_a;
  logic [uht_pkg::HANDLE_BITS-1:0] alu_b;
  uht_pkg::uht_alu_out_t           alu_out;
  uht_pkg::uht_cmd_t               in_cmd;

  uht_slot_mem u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  uht_alu u_alu (
    .op_a (alu_a),
    .op_b (alu_b),
    .res  (alu_out)
  );

  assign in_cmd = uht_pkg::uht_cmd_t'(in_command);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= uht_pkg::ST_CLEAR;
      clr_addr_r    <= '0;
      last_issued_r <= '0;
      used_count_r  <= '0;
      quick_r       <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      clr_addr_r    <= clr_addr_nxt;
      last_issued_r <= last_issued_nxt;
      used_count_r  <= used_count_nxt;
      quick_r       <= quick_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r          <= cmd_nxt;
    handle_r       <= handle_nxt;
    ref_r          <= ref_nxt;
    quick_status_r <= quick_status_nxt;
  end

  always_comb begin
    state_nxt        = state_r;
    clr_addr_nxt     = clr_addr_r;
    last_issued_nxt  = last_issued_r;
    used_count_nxt   = used_count_r;
    cmd_nxt          = cmd_r;
    handle_nxt       = handle_r;
    ref_nxt          = ref_r;
    quick_nxt        = quick_r;
    quick_status_nxt = quick_status_r;
    wr_en            = 1'b0;
    wr_addr          = uht_pkg::SLOT_BITS'(handle_r);
    wr_data          = '0;
    rd_en            = 1'b0;
    rd_addr          = uht_pkg::SLOT_BITS'(handle_r);
    in_ready         = 1'b0;
    res_valid        = 1'b0;
    res              = '0;
    res.status       = uht_pkg::STATUS_OK;
    alu_a            = handle_r;
    alu_b            = last_issued_r;

    unique case (state_r)
      uht_pkg::ST_CLEAR: begin
        wr_en        = 1'b1;
        wr_addr      = clr_addr_r;
        clr_addr_nxt = clr_addr_r + uht_pkg::SLOT_BITS'(1);
        if (clr_addr_r == uht_pkg::SLOT_BITS'(uht_pkg::TABLE_SLOTS - 1)) begin
          state_nxt = uht_pkg::ST_IDLE;
        end
      end

      uht_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        alu_a    = in_handle_in;
        alu_b    = last_issued_r;
        if (in_valid) begin
          cmd_nxt          = in_cmd;
          handle_nxt       = in_handle_in;
          ref_nxt          = in_store_ref;
          quick_nxt        = 1'b0;
          quick_status_nxt = uht_pkg::STATUS_OK;
          state_nxt        = uht_pkg::ST_CHECK;
          unique case (in_cmd)
            uht_pkg::CMD_ALLOC: begin
              if (in_store_ref == '0) begin
                quick_nxt        = 1'b1;
                quick_status_nxt = uht_pkg::STATUS_ZERO_REF;
              end else if (used_count_r > uht_pkg::COUNT_BITS'(uht_pkg::HALF_SLOTS)) begin
                quick_nxt        = 1'b1;
                quick_status_nxt = uht_pkg::STATUS_FULL;
              end else begin
                last_issued_nxt = alu_out.b_next;
                rd_en           = 1'b1;
                rd_addr         = uht_pkg::SLOT_BITS'(alu_out.b_next);
              end
            end
            uht_pkg::CMD_LOOKUP: begin
              if (in_handle_in == '0 || alu_out.a_gt_b) begin
                quick_nxt        = 1'b1;
                quick_status_nxt = uht_pkg::STATUS_INVALID;
              end else begin
                rd_en   = 1'b1;
                rd_addr = uht_pkg::SLOT_BITS'(in_handle_in);
              end
            end
            uht_pkg::CMD_FREE: begin
              if (in_handle_in == '0) begin
                quick_nxt        = 1'b1;
                quick_status_nxt = uht_pkg::STATUS_INVALID;
              end else begin
                rd_en   = 1'b1;
                rd_addr = uht_pkg::SLOT_BITS'(in_handle_in);
              end
            end
            uht_pkg::CMD_SHORT: begin
              rd_en   = 1'b1;
              rd_addr = uht_pkg::SLOT_BITS'(in_short_handle);
            end
            default: begin
              rd_en = 1'b0;
            end
          endcase
        end
      end

      uht_pkg::ST_CHECK: begin
        alu_a = handle_r;
        alu_b = (cmd_r == uht_pkg::CMD_ALLOC) ? last_issued_r : rd_data.handle;
        if (quick_r) begin
          res_valid  = 1'b1;
          res.status = quick_status_r;
          if (out_free) begin
            state_nxt = uht_pkg::ST_IDLE;
          end
        end else begin
          unique case (cmd_r)
            uht_pkg::CMD_ALLOC: begin
              if (rd_data.ref_val == '0) begin
                res_valid  = 1'b1;
                res.handle = last_issued_r;
                if (out_free) begin
                  wr_en          = 1'b1;
                  wr_addr        = uht_pkg::SLOT_BITS'(last_issued_r);
                  wr_data.handle = last_issued_r;
                  wr_data.ref_val = ref_r;
                  used_count_nxt = used_count_r + uht_pkg::COUNT_BITS'(1);
                  state_nxt      = uht_pkg::ST_IDLE;
                end
              end else begin
                last_issued_nxt = alu_out.b_next;
                rd_en           = 1'b1;
                rd_addr         = uht_pkg::SLOT_BITS'(alu_out.b_next);
              end
            end
            uht_pkg::CMD_LOOKUP: begin
              res_valid = 1'b1;
              if (alu_out.a_eq_b) begin
                res.handle  = handle_r;
                res.ref_val = rd_data.ref_val;
              end else begin
                res.status = uht_pkg::STATUS_NOT_FOUND;
              end
              if (out_free) begin
                state_nxt = uht_pkg::ST_IDLE;
              end
            end
            uht_pkg::CMD_FREE: begin
              res_valid = 1'b1;
              if (alu_out.a_eq_b) begin
                res.handle = handle_r;
                if (out_free) begin
                  wr_en   = 1'b1;
                  wr_addr = uht_pkg::SLOT_BITS'(handle_r);
                  if (used_count_r != '0) begin
                    used_count_nxt = used_count_r - uht_pkg::COUNT_BITS'(1);
                  end
                end
              end else begin
                res.status = uht_pkg::STATUS_INVALID;
              end
              if (out_free) begin
                state_nxt = uht_pkg::ST_IDLE;
              end
            end
            uht_pkg::CMD_SHORT: begin
              res_valid = 1'b1;
              if (rd_data.ref_val == '0) begin
                res.status = uht_pkg::STATUS_NOT_FOUND;
              end else begin
                res.handle = rd_data.handle;
              end
              if (out_free) begin
                state_nxt = uht_pkg::ST_IDLE;
              end
            end
            default: begin
              state_nxt = uht_pkg::ST_IDLE;
            end
          endcase
        end
      end

      default: begin
        state_nxt = uht_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: src/uht_checker.sv
// ---------------------------------------------------------------------------
// Handle table port checker
// Watches the core's ports for handshake and result word consistency.
// ---------------------------------------------------------------------------
module uht_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [uht_pkg::STATUS_BITS-1:0] out_status,
  input logic [uht_pkg::HANDLE_BITS-1:0] out_handle,
  input logic [uht_pkg::REF_BITS-1:0]    out_ref
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
    $stable(out_handle) && $stable(out_ref))
    else $error("Output word changed while stalled.");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("Core active right after reset.");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= uht_pkg::STATUS_BITS'(uht_pkg::STATUS_ZERO_REF))
    else $error("Output status out of range.");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != uht_pkg::STATUS_BITS'(uht_pkg::STATUS_OK) |->
    out_handle == '0 && out_ref == '0)
    else $error("Failed command returned nonzero fields.");

  a_ref_only_on_lookup_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ref != '0 |-> out_handle != '0)
    else $error("Reference returned without a handle.");

endmodule

bind unique_handle_table_core uht_checker u_uht_checker (.*);

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Unique handle table core testbench
// Drives allocate, lookup, free and short-to-full command words through the
// input handshake and checks every result word against the typed expected word
// of a directed row or against a local model of the table kept in step with the
// accepted commands. A directed table covers the corner cases, and random
// traffic then churns and fills the table under bursty input and a stalling output.
// ---------------------------------------------------------------------------
module tb_top;
  import uht_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int END_CYCLES  = 2 * TABLE_SLOTS;
  localparam int RUN_LIMIT   = 1800 * (4 * TABLE_SLOTS) + 4 * TABLE_SLOTS;
  localparam int NUM_DIR     = 24;

  typedef enum {MIX_CHURN, MIX_FILL, MIX_QUERY} traffic_mix_t;

  typedef struct packed {
    uht_cmd_t                cmd;
    logic [HANDLE_BITS-1:0]  handle;
    logic [REF_BITS-1:0]     ref_val;
    logic [SHORT_BITS-1:0]   short_h;
    logic                    typed;
    uht_result_t             res;
  } stim_row_t;

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [CMD_BITS-1:0]    in_command = '0;
  logic [HANDLE_BITS-1:0] in_handle_in = '0;
  logic [REF_BITS-1:0]    in_store_ref = '0;
  logic [SHORT_BITS-1:0]  in_short_handle = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [STATUS_BITS-1:0] out_status;
  logic [HANDLE_BITS-1:0] out_handle;
  logic [REF_BITS-1:0]    out_ref;

  logic [HANDLE_BITS-1:0] handle_mem [TABLE_SLOTS];
  logic [REF_BITS-1:0]    ref_mem [TABLE_SLOTS];
  int                     used_cnt = 0;
  logic [HANDLE_BITS-1:0] last_handle = '0;

  uht_result_t            result_q [$];
  int                     mismatch_cnt = 0;
  int unsigned            cycle_cnt = 0;
  int                     burst_left = 0;
  int                     hold_asked = 0;

  stim_row_t dir_rows [NUM_DIR] = '{
    '{CMD_LOOKUP, 32'h0,         32'h0,         16'h0000, 1'b1, '{STATUS_INVALID, 32'h0, 32'h0}},
    '{CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0,         16'h0000, 1'b1, '{STATUS_INVALID, 32'h0, 32'h0}},
    '{CMD_FREE,   32'h0,         32'h0,         16'h0000, 1'b1, '{STATUS_INVALID, 32'h0, 32'h0}},
    '{CMD_SHORT,  32'h0,         32'h0,         16'h0000, 1'b1,
      '{STATUS_NOT_FOUND, 32'h0, 32'h0}},
    '{CMD_SHORT,  32'h0,         32'h0,         16'hFFFF, 1'b1,
      '{STATUS_NOT_FOUND, 32'h0, 32'h0}},
    '{CMD_ALLOC,  32'h0,         32'h0,         16'h0000, 1'b1,
      '{STATUS_ZERO_REF, 32'h0, 32'h0}},
    '{CMD_ALLOC,  32'h0,         32'hFFFF_FFFF, 16'h0000, 1'b1, '{STATUS_OK, 32'h1, 32'h0}},
    '{CMD_ALLOC,  32'h0,         32'h1,         16'h0000, 1'b1, '{STATUS_OK, 32'h2, 32'h0}},
    '{CMD_ALLOC,  32'h0,         32'h5A5A_A5A5, 16'h0000, 1'b0, '{STATUS_OK, 32'h0, 32'h0}},
    '{CMD_LOOKUP, 32'h1,         32'h0,         16'h0000, 1'b1,
      '{STATUS_OK, 32'h1, 32'hFFFF_FFFF}},
    '{CMD_LOOKUP, 32'h2,         32'h0,         16'h0000, 1'b1, '{STATUS_OK, 32'h2, 32'h1}},
    '{CMD_LOOKUP, 32'h4,         32'h0,         16'h0000, 1'b1, '{STATUS_INVALID, 32'h0, 32'h0}},
    '{CMD_SHORT,  32'h0,         32'h0,         16'h0001, 1'b1, '{STATUS_OK, 32'h1, 32'h0}},
    '{CMD_SHORT,  32'h0,         32'h0,         16'hFC01, 1'b1, '{STATUS_OK, 32'h1, 32'h0}},
    '{CMD_FREE,   32'h1,         32'h0,         16'h0000, 1'b1, '{STATUS_OK, 32'h1, 32'h0}},
    '{CMD_FREE,   32'h1,         32'h0,         16'h0000, 1'b1, '{STATUS_INVALID, 32'h0, 32'h0}},
    '{CMD_LOOKUP, 32'h1,         32'h0,         16'h0000, 1'b1,
      '{STATUS_NOT_FOUND, 32'h0, 32'h0}},
    '{CMD_SHORT,  32'h0,         32'h0,         16'h0001, 1'b1,
      '{STATUS_NOT_FOUND, 32'h0, 32'h0}},
    '{CMD_FREE,   32'hFFFF_FFFF, 32'h0,         16'h0000, 1'b1, '{STATUS_INVALID, 32'h0, 32'h0}},
    '{CMD_LOOKUP, 32'h3,         32'h0,         16'h0000, 1'b0, '{STATUS_OK, 32'h0, 32'h0}},
    '{CMD_FREE,   32'h401,       32'h0,         16'h0000, 1'b1, '{STATUS_INVALID, 32'h0, 32'h0}},
    '{CMD_ALLOC,  32'h0,         32'h8000_0000, 16'h0000, 1'b0, '{STATUS_OK, 32'h0, 32'h0}},
    '{CMD_FREE,   32'h3,         32'h0,         16'h0000, 1'b0, '{STATUS_OK, 32'h0, 32'h0}},
    '{CMD_SHORT,  32'h0,         32'h0,         16'h0402, 1'b0, '{STATUS_OK, 32'h0, 32'h0}}
  };

  unique_handle_table_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_handle_in    (in_handle_in),
    .in_store_ref    (in_store_ref),
    .in_short_handle (in_short_handle),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_handle      (out_handle),
    .out_ref         (out_ref)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    foreach (handle_mem[i]) begin
      handle_mem[i] = '0;
      ref_mem[i] = '0;
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == RUN_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Applies one command word to the local table and returns its result word.
  function automatic uht_result_t table_apply(uht_cmd_t cmd, logic [HANDLE_BITS-1:0] h,
                                              logic [REF_BITS-1:0] r,
                                              logic [SHORT_BITS-1:0] sh);
    uht_result_t          res;
    logic [SLOT_BITS-1:0] s;
    bit                   placed;
    int                   probe;
    res = '0;
    placed = 1'b0;
    case (cmd)
      CMD_ALLOC: begin
        if (r == '0) begin
          res.status = STATUS_ZERO_REF;
        end else if (used_cnt * 2 > TABLE_SLOTS) begin
          res.status = STATUS_FULL;
        end else begin
          res.status = STATUS_FULL;
          for (probe = 0; probe <= TABLE_SLOTS && !placed; probe++) begin
            last_handle = last_handle + 1'b1;
            if (last_handle == '0) last_handle = 1;
            s = last_handle[SLOT_BITS-1:0];
            if (ref_mem[s] == '0) begin
              ref_mem[s] = r;
              handle_mem[s] = last_handle;
              used_cnt++;
              placed = 1'b1;
              res.status = STATUS_OK;
              res.handle = last_handle;
            end
          end
        end
      end
      CMD_LOOKUP: begin
        s = h[SLOT_BITS-1:0];
        if (h == '0 || h > last_handle) begin
          res.status = STATUS_INVALID;
        end else if (handle_mem[s] == h) begin
          res.status = STATUS_OK;
          res.handle = h;
          res.ref_val = ref_mem[s];
        end else begin
          res.status = STATUS_NOT_FOUND;
        end
      end
      CMD_FREE: begin
        s = h[SLOT_BITS-1:0];
        if (h != '0 && handle_mem[s] == h) begin
          handle_mem[s] = '0;
          ref_mem[s] = '0;
          if (used_cnt > 0) used_cnt--;
          res.status = STATUS_OK;
          res.handle = h;
        end else begin
          res.status = STATUS_INVALID;
        end
      end
      default: begin
        s = sh[SLOT_BITS-1:0];
        if (ref_mem[s] == '0) begin
          res.status = STATUS_NOT_FOUND;
        end else begin
          res.status = STATUS_OK;
          res.handle = handle_mem[s];
        end
      end
    endcase
    return res;
  endfunction

  // Mostly live handles, with stale, future, zero and arbitrary ones mixed in.
  function automatic logic [HANDLE_BITS-1:0] pick_handle();
    int                     roll;
    int                     tries;
    logic [SLOT_BITS-1:0]   s;
    logic [HANDLE_BITS-1:0] live;
    roll = $urandom_range(0, 99);
    live = last_handle;
    tries = 0;
    do begin
      s = SLOT_BITS'($urandom_range(0, TABLE_SLOTS - 1));
      tries++;
    end while (ref_mem[s] == '0 && tries < 8);
    if (ref_mem[s] != '0) live = handle_mem[s];
    if (roll < 50) return live;
    else if (roll < 62) return last_handle - $urandom_range(0, 2 * TABLE_SLOTS);
    else if (roll < 70) return live + TABLE_SLOTS;
    else if (roll < 78) return last_handle + $urandom_range(1, 3);
    else if (roll < 85) return '0;
    return $urandom;
  endfunction

  task automatic send_word(uht_cmd_t cmd, logic [HANDLE_BITS-1:0] h,
                           logic [REF_BITS-1:0] r, logic [SHORT_BITS-1:0] sh,
                           logic typed, uht_result_t typed_res);
    int          gap;
    uht_result_t res;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid        <= 1'b1;
    in_command      <= cmd;
    in_handle_in    <= h;
    in_store_ref    <= r;
    in_short_handle <= sh;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    res = table_apply(cmd, h, r, sh);
    result_q.push_back(typed ? typed_res : res);
  endtask

  task automatic run_traffic(traffic_mix_t mix, int count);
    int                     n;
    int                     roll;
    uht_cmd_t               cmd;
    logic [HANDLE_BITS-1:0] h;
    logic [REF_BITS-1:0]    r;
    logic [SHORT_BITS-1:0]  sh;
    for (n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      case (mix)
        MIX_CHURN: cmd = (roll < 50) ? CMD_ALLOC : (roll < 85) ? CMD_FREE :
                         (roll < 95) ? CMD_LOOKUP : CMD_SHORT;
        MIX_FILL:  cmd = (roll < 94) ? CMD_ALLOC : (roll < 97) ? CMD_LOOKUP : CMD_SHORT;
        default:   cmd = (roll < 30) ? CMD_ALLOC : (roll < 60) ? CMD_LOOKUP :
                         (roll < 85) ? CMD_FREE : CMD_SHORT;
      endcase
      h = pick_handle();
      roll = $urandom_range(0, 99);
      r = (roll < 5) ? '0 : (roll < 10) ? '1 : $urandom;
      sh = SHORT_BITS'($urandom);
      if ($urandom_range(0, 1) == 1)
        sh[SLOT_BITS-1:0] = SLOT_BITS'(last_handle[SLOT_BITS-1:0] - $urandom_range(0, 7));
      send_word(cmd, h, r, sh, 1'b0, '0);
    end
  endtask

  initial begin : word_source
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    foreach (dir_rows[i])
      send_word(dir_rows[i].cmd, dir_rows[i].handle, dir_rows[i].ref_val,
                dir_rows[i].short_h, dir_rows[i].typed, dir_rows[i].res);
    run_traffic(MIX_CHURN, 300);
    run_traffic(MIX_FILL, 600);
    in_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    hold_asked++;
    run_traffic(MIX_CHURN, 550);
    run_traffic(MIX_QUERY, 250);
    in_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && result_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : result_sink
    uht_result_t exp_res;
    int          mode_left;
    int          ready_pct;
    int          hold_left;
    int          hold_done;
    mode_left = 0;
    ready_pct = 100;
    hold_left = 0;
    hold_done = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected word: status %0d handle %h ref %h", $time,
                   out_status, out_handle, out_ref);
          mismatch_cnt++;
        end else begin
          exp_res = result_q.pop_front();
          if (out_status !== exp_res.status) begin
            $display("%0t: out_status expected %0d, actual %0d", $time,
                     exp_res.status, out_status);
            mismatch_cnt++;
          end
          if (out_handle !== exp_res.handle) begin
            $display("%0t: out_handle expected %h, actual %h", $time,
                     exp_res.handle, out_handle);
            mismatch_cnt++;
          end
          if (out_ref !== exp_res.ref_val) begin
            $display("%0t: out_ref expected %h, actual %h", $time,
                     exp_res.ref_val, out_ref);
            mismatch_cnt++;
          end
        end
      end
      if (hold_done != hold_asked) begin
        hold_done = hold_asked;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode_left = $urandom_range(20, 200);
        case ($urandom_range(0, 3))
          0: ready_pct = 100;
          1: ready_pct = 75;
          2: ready_pct = 30;
          default: ready_pct = 90;
        endcase
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(1, 100) <= ready_pct);
      end
    end
  end

endmodule
